// ===== rtl/dlr_pkg.sv =====
// shared types, widths and codes for the dda line rasteriser
// no dependencies; every rtl file refers to this package by scoped names
package dlr_pkg;

    // geometry and fixed-point format
    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = COORD_BITS + FRAC_BITS;   // unsigned position, biased by one half
    localparam int STEP_W     = FRAC_BITS + 2;            // signed q1.frac increment
    localparam int QUOT_W     = FRAC_BITS + 1;            // increment magnitude, at most 1.0
    localparam int CNT_W      = $clog2(QUOT_W);
    localparam int REM_W      = COORD_BITS + 1;

    // configuration registers
    localparam int COLOR_W    = 32;
    localparam int SIZE_W     = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_RADIUS  = 1'd1;
    localparam logic [COLOR_W-1:0]   COLOR_RESET     = 32'hFFFF_0000;
    localparam logic [SIZE_W-1:0]    SIZE_RESET      = 8'd5;

    // request kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // stream widths
    localparam int IN_FIELDS_W  = 4 * COORD_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_BITS + COLOR_W + SIZE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // classified request as held in the queue
    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] steps;    // larger of |dx| and |dy|
        logic [COORD_BITS-1:0] minor;    // smaller of |dx| and |dy|
        logic                  x_major;
        logic                  x_neg;
        logic                  y_neg;
    } t_cmd;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/dlr_front.sv =====
// request classifier: unpacks endpoints, finds major axis, step count and signs
// depends on dlr_pkg
module dlr_front (
    input  logic                             i_valid,
    input  logic [dlr_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic                             i_tuser,
    output logic                             o_ready,
    input  logic                             i_full,
    output logic                             o_push,
    output dlr_pkg::t_cmd                    o_cmd
);

    localparam int C = dlr_pkg::COORD_BITS;

    logic [C-1:0] xs, ys, xe, ye;
    logic [C-1:0] adx, ady;
    logic         x_neg, y_neg, x_major;

    assign xs = i_tdata[C-1:0];
    assign ys = i_tdata[2*C-1:C];
    assign xe = i_tdata[3*C-1:2*C];
    assign ye = i_tdata[4*C-1:3*C];

    always_comb begin
        x_neg   = xe < xs;
        y_neg   = ye < ys;
        adx     = x_neg ? xs - xe : xe - xs;
        ady     = y_neg ? ys - ye : ye - ys;
        x_major = adx >= ady;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.mode    = i_tuser;
        o_cmd.x_start = xs;
        o_cmd.y_start = ys;
        o_cmd.steps   = x_major ? adx : ady;
        o_cmd.minor   = x_major ? ady : adx;
        o_cmd.x_major = x_major;
        o_cmd.x_neg   = x_neg;
        o_cmd.y_neg   = y_neg;
    end

endmodule

// ===== rtl/dlr_fifo.sv =====
// short command queue between classifier and stepping engine
// depends on dlr_pkg
module dlr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dlr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output dlr_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    dlr_pkg::t_cmd r_mem [dlr_pkg::Q_DEPTH];
    logic [dlr_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [dlr_pkg::Q_CNT_W-1:0] r_count;

    assign o_full  = r_count == dlr_pkg::Q_CNT_W'(dlr_pkg::Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dlr_div.sv =====
// radix-2 restoring divider for the minor-axis increment, one quotient bit per cycle
// depends on dlr_pkg
module dlr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlr_pkg::t_div_req i_req,
    output dlr_pkg::t_div_rsp o_rsp
);

    localparam int C = dlr_pkg::COORD_BITS;

    logic                         r_busy, r_done;
    logic [dlr_pkg::CNT_W-1:0]    r_cnt;
    logic [dlr_pkg::REM_W-1:0]    r_rem;
    logic [C-1:0]                 r_den;
    logic [dlr_pkg::QUOT_W-1:0]   r_quot;

    logic                         ge;
    logic [dlr_pkg::REM_W-1:0]    diff;

    always_comb begin
        ge   = r_rem >= {1'b0, r_den};
        diff = ge ? r_rem - {1'b0, r_den} : r_rem;
    end

    // partial remainder starts at num since the low dividend bits are zero
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {1'b0, i_req.num};
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {diff[C-1:0], 1'b0};
            r_quot <= {r_quot[dlr_pkg::QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= dlr_pkg::CNT_W'(dlr_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/dlr_back.sv =====
// stepping engine: loads lines, forms increments, advances accumulators, drives result register
// depends on dlr_pkg; uses dlr_div through the request and response structs
module dlr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dlr_pkg::t_cmd                     i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    output dlr_pkg::t_div_req                 o_div_req,
    input  dlr_pkg::t_div_rsp                 i_div_rsp,
    input  logic [dlr_pkg::COLOR_W-1:0]       i_color,
    input  logic [dlr_pkg::SIZE_W-1:0]        i_size,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dlr_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic                              o_tlast
);

    localparam int C   = dlr_pkg::COORD_BITS;
    localparam int F   = dlr_pkg::FRAC_BITS;
    localparam int AW  = dlr_pkg::ACC_W;
    localparam int SW  = dlr_pkg::STEP_W;
    localparam int PAD = dlr_pkg::OUT_TDATA_W - dlr_pkg::OUT_FIELDS_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    localparam logic [dlr_pkg::QUOT_W-1:0] ONE = {1'b1, {F{1'b0}}};

    logic              r_state;
    logic              r_line_active;
    logic [AW-1:0]     r_x_acc, r_y_acc;
    logic [SW-1:0]     r_x_step, r_y_step;
    logic [C-1:0]      r_steps_left;
    logic              r_x_major, r_x_neg, r_y_neg;

    logic              r_out_valid, r_out_last;
    logic [C-1:0]      r_out_x, r_out_y;
    logic [dlr_pkg::COLOR_W-1:0] r_out_color;
    logic [dlr_pkg::SIZE_W-1:0]  r_out_size;

    logic              slot_free, is_load, is_zero;
    logic [AW-1:0]     n_x_acc, n_y_acc;
    logic [AW-1:0]     load_x_acc, load_y_acc;
    logic [dlr_pkg::QUOT_W-1:0] x_mag, y_mag;
    logic [SW-1:0]     n_x_step, n_y_step;

    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = !i_empty && (r_state == ST_IDLE) && slot_free;
    assign is_load   = i_cmd.mode == dlr_pkg::MODE_LOAD;
    assign is_zero   = i_cmd.steps == '0;

    // accumulators carry a half-pixel bias so rounding is a plain slice
    assign load_x_acc = {i_cmd.x_start, 1'b1, {(F-1){1'b0}}};
    assign load_y_acc = {i_cmd.y_start, 1'b1, {(F-1){1'b0}}};
    assign n_x_acc    = r_x_acc + {{(AW-SW){r_x_step[SW-1]}}, r_x_step};
    assign n_y_acc    = r_y_acc + {{(AW-SW){r_y_step[SW-1]}}, r_y_step};

    // major axis moves by exactly one pixel
    always_comb begin
        x_mag    = r_x_major ? ONE : i_div_rsp.quot;
        y_mag    = r_x_major ? i_div_rsp.quot : ONE;
        n_x_step = r_x_neg ? SW'(-{1'b0, x_mag}) : {1'b0, x_mag};
        n_y_step = r_y_neg ? SW'(-{1'b0, y_mag}) : {1'b0, y_mag};
    end

    always_comb begin
        o_div_req.start = o_pop && is_load && !is_zero;
        o_div_req.num   = i_cmd.minor;
        o_div_req.den   = i_cmd.steps;
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_line_active <= 1'b0;
            r_steps_left  <= '0;
            r_x_acc       <= '0;
            r_y_acc       <= '0;
            r_x_step      <= '0;
            r_y_step      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && is_load) begin
                        r_x_acc       <= load_x_acc;
                        r_y_acc       <= load_y_acc;
                        r_steps_left  <= i_cmd.steps;
                        r_line_active <= !is_zero;
                        if (!is_zero) begin
                            r_state <= ST_DIV;
                        end
                    end else if (o_pop && r_line_active) begin
                        r_x_acc      <= n_x_acc;
                        r_y_acc      <= n_y_acc;
                        r_steps_left <= r_steps_left - 1'b1;
                        if (r_steps_left == C'(1)) begin
                            r_line_active <= 1'b0;
                        end
                    end
                end
                ST_DIV: begin
                    if (i_div_rsp.done) begin
                        r_x_step <= n_x_step;
                        r_y_step <= n_y_step;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_load) begin
            r_x_major <= i_cmd.x_major;
            r_x_neg   <= i_cmd.x_neg;
            r_y_neg   <= i_cmd.y_neg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && (is_load || r_line_active)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_load) begin
            r_out_x     <= i_cmd.x_start;
            r_out_y     <= i_cmd.y_start;
            r_out_last  <= is_zero;
            r_out_color <= i_color;
            r_out_size  <= i_size;
        end else if (o_pop && r_line_active) begin
            r_out_x     <= n_x_acc[AW-1:F];
            r_out_y     <= n_y_acc[AW-1:F];
            r_out_last  <= r_steps_left == C'(1);
            r_out_color <= i_color;
            r_out_size  <= i_size;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tlast = r_out_last;
    assign o_tdata = {{PAD{1'b0}}, r_out_size, r_out_color, r_out_y, r_out_x};

endmodule

// ===== rtl/dda_line_rasterizer.sv =====
// top level of the dda line rasteriser: configuration registers, classifier,
// command queue, divider and stepping engine; depends on dlr_pkg and all dlr_ modules
//
// a load request (tuser 0) carries two endpoints and emits the start point; each step
// request (tuser 1) emits the next point of the line, the final one with tlast set. a
// step request with no line in progress is consumed and gives nothing. step requests
// are taken back to back while the output drains. a load of a non-degenerate line
// emits its first point at once, then runs the restoring divider for the minor-axis
// increment, one quotient bit per cycle, and takes the increments up when the divider
// signals done; only then does the next request leave the queue. meanwhile later
// requests wait in the two-entry queue, and the input stays ready while the queue has
// room. every point carries the colour and dot radius as configured; the user must
// write configuration only while the block is idle; the block does not enforce this
module dda_line_rasterizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_start, y_start, x_end, y_end, zero pad
    input  logic [dlr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic                                s_axis_tuser,
    // point stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // point_x, point_y, dot_color, dot_size, zero pad
    output logic [dlr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // last_point
    output logic                                m_axis_tlast,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [dlr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dlr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [dlr_pkg::COLOR_W-1:0] r_pixel_color;
    logic [dlr_pkg::SIZE_W-1:0]  r_dot_radius;

    logic              q_push, q_full, q_pop, q_empty;
    dlr_pkg::t_cmd     push_cmd, head_cmd;
    dlr_pkg::t_div_req div_req;
    dlr_pkg::t_div_rsp div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_color <= dlr_pkg::COLOR_RESET;
            r_dot_radius  <= dlr_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dlr_pkg::CFG_PIXEL_COLOR: r_pixel_color <= i_cfg_data[dlr_pkg::COLOR_W-1:0];
                dlr_pkg::CFG_DOT_RADIUS:  r_dot_radius  <= i_cfg_data[dlr_pkg::SIZE_W-1:0];
            endcase
        end
    end

    // front: classify the request into a queue entry
    dlr_front u_front (
        .i_valid (s_axis_tvalid),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (push_cmd)
    );

    // queue decouples input acceptance from line stepping
    dlr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    // increment divider, shared by both axes since the major axis needs none
    dlr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // back: accumulators and the output register
    dlr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_empty   (q_empty),
        .o_pop     (q_pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .i_color   (r_pixel_color),
        .i_size    (r_dot_radius),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

    // a new division never starts over one in flight
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a started division is running on the next cycle
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> div_rsp.busy)
        else $error("divider did not start");

    // completion is a single-cycle pulse
    a_div_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |=> !div_rsp.done)
        else $error("divider done held for more than one cycle");

    // nothing leaves the queue while the increments are still being formed
    a_no_pop_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> !q_pop)
        else $error("queue popped during division");

endmodule

// ===== bench/dlr_checker.sv =====
`timescale 1ns / 1ps
// point checker for the dda line rasteriser: follows the request, point and configuration
// ports, works out every point from its own copy of the line state and compares fields
// depends on dlr_pkg
module dlr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [dlr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [dlr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [dlr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dlr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int CB     = dlr_pkg::COORD_BITS;
    localparam int FB     = dlr_pkg::FRAC_BITS;
    localparam int POS_W  = CB + FB + 1;
    localparam int STEP_W = dlr_pkg::STEP_W;

    typedef struct packed {
        logic [CB-1:0]                  x;
        logic [CB-1:0]                  y;
        logic                           last;
        logic [dlr_pkg::COLOR_W-1:0]    color;
        logic [dlr_pkg::SIZE_W-1:0]     size;
    } t_point;

    t_point                         points_due[$];
    logic [dlr_pkg::COLOR_W-1:0]    colour_reg;
    logic [dlr_pkg::SIZE_W-1:0]     radius_reg;
    logic                           line_on;
    logic [POS_W-1:0]               x_pos;
    logic [POS_W-1:0]               y_pos;
    logic signed [STEP_W-1:0]       x_inc;
    logic signed [STEP_W-1:0]       y_inc;
    logic [CB:0]                    steps_rem;
    int                             fails = 0;

    // round half up to the nearest pixel
    function automatic logic [CB-1:0] to_pixel(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] biased;
        biased = pos + (POS_W'(1) << (FB - 1));
        return biased[FB +: CB];
    endfunction

    // signed increment, magnitude truncated toward zero
    function automatic logic signed [STEP_W-1:0] slope(input int d, input int n);
        logic [STEP_W-1:0] mag;
        mag = STEP_W'((((d < 0) ? -d : d) * (1 << FB)) / n);
        return (d < 0) ? -mag : mag;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_point point_now(input logic last);
        t_point p;
        p.x     = to_pixel(x_pos);
        p.y     = to_pixel(y_pos);
        p.last  = last;
        p.color = colour_reg;
        p.size  = radius_reg;
        return p;
    endfunction

    task automatic compare(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : follow
        logic [CB-1:0] xs, ys, xe, ye;
        int            dx, dy, n;
        t_point        got, want;
        if (!i_rst_n) begin
            colour_reg = dlr_pkg::COLOR_RESET;
            radius_reg = dlr_pkg::SIZE_RESET;
            line_on    = 1'b0;
            x_pos      = '0;
            y_pos      = '0;
            x_inc      = '0;
            y_inc      = '0;
            steps_rem  = '0;
            points_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dlr_pkg::CFG_PIXEL_COLOR: colour_reg = i_cfg_data[dlr_pkg::COLOR_W-1:0];
                    dlr_pkg::CFG_DOT_RADIUS:  radius_reg = i_cfg_data[dlr_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
            // requests first, so a point leaving on the same edge still finds its entry
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == dlr_pkg::MODE_LOAD) begin
                    xs = s_axis_tdata[0 +: CB];
                    ys = s_axis_tdata[CB +: CB];
                    xe = s_axis_tdata[2*CB +: CB];
                    ye = s_axis_tdata[3*CB +: CB];
                    dx = int'(xe) - int'(xs);
                    dy = int'(ye) - int'(ys);
                    n  = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
                    x_pos = POS_W'({xs, {FB{1'b0}}});
                    y_pos = POS_W'({ys, {FB{1'b0}}});
                    if (n == 0) begin
                        x_inc     = '0;
                        y_inc     = '0;
                        steps_rem = '0;
                        line_on   = 1'b0;
                        points_due.push_back(point_now(1'b1));
                    end else begin
                        x_inc     = slope(dx, n);
                        y_inc     = slope(dy, n);
                        steps_rem = (CB+1)'(n);
                        line_on   = 1'b1;
                        points_due.push_back(point_now(1'b0));
                    end
                end else if (line_on) begin
                    x_pos     = x_pos + POS_W'(x_inc);
                    y_pos     = y_pos + POS_W'(y_inc);
                    steps_rem = steps_rem - 1'b1;
                    if (steps_rem == 0)
                        line_on = 1'b0;
                    points_due.push_back(point_now(steps_rem == 0));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.x     = m_axis_tdata[0 +: CB];
                got.y     = m_axis_tdata[CB +: CB];
                got.color = m_axis_tdata[2*CB +: dlr_pkg::COLOR_W];
                got.size  = m_axis_tdata[2*CB+dlr_pkg::COLOR_W +: dlr_pkg::SIZE_W];
                got.last  = m_axis_tlast;
                if (points_due.size() == 0) begin
                    $error("point with none expected: x=%0d y=%0d", got.x, got.y);
                    fails++;
                end else begin
                    want = points_due.pop_front();
                    compare("point_x", 32'(want.x), 32'(got.x));
                    compare("point_y", 32'(want.y), 32'(got.y));
                    compare("last_point", 32'(want.last), 32'(got.last));
                    compare("dot_color", want.color, got.color);
                    compare("dot_size", 32'(want.size), 32'(got.size));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= points_due.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// top of the dda line rasteriser bench: clock, reset, request and configuration stimulus,
// random back-pressure and the verdict; depends on dlr_pkg, dlr_checker and the rtl
module tb;

    localparam int CB         = dlr_pkg::COORD_BITS;
    localparam int COORD_MAX  = (1 << CB) - 1;
    localparam int PAD_W      = dlr_pkg::IN_TDATA_W - dlr_pkg::IN_FIELDS_W;
    localparam int PHASE_REQS = 375;     // useful requests per random phase
    localparam int SETTLE     = 60;      // covers the divider and the queued requests
    localparam int STALL_MAX  = 5000;    // cycles with no handshake before giving up

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [dlr_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic                               s_tuser = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [dlr_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               m_tlast;
    logic                               cfg_we = 1'b0;
    logic [dlr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [dlr_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    int                                 fail_count;
    int                                 pending;

    // stimulus bookkeeping: requests that make a point, and steps the current line still owes
    int                                 useful = 0;
    int                                 owed = 0;
    logic                               calm = 1'b0;   // no idling on either side
    int                                 rdy_hold = 0;
    int                                 stall_cycles = 0;

    always #6 clk = ~clk;

    dda_line_rasterizer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .s_axis_tvalid  (s_tvalid),
        .s_axis_tready  (s_tready),
        .s_axis_tdata   (s_tdata),      // x_start, y_start, x_end, y_end, zero pad
        .s_axis_tuser   (s_tuser),      // mode
        .m_axis_tvalid  (m_tvalid),
        .m_axis_tready  (m_tready),
        .m_axis_tdata   (m_tdata),      // point_x, point_y, dot_color, dot_size, zero pad
        .m_axis_tlast   (m_tlast),      // last_point
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    dlr_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .s_axis_tvalid  (s_tvalid),
        .s_axis_tready  (s_tready),
        .s_axis_tdata   (s_tdata),
        .s_axis_tuser   (s_tuser),
        .m_axis_tvalid  (m_tvalid),
        .m_axis_tready  (m_tready),
        .m_axis_tdata   (m_tdata),
        .m_axis_tlast   (m_tlast),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // point-side back-pressure: runs of ready and stall, mostly short, now and then long
    always @(negedge clk) begin
        if (rdy_hold > 0) begin
            rdy_hold = rdy_hold - 1;
        end else if (calm) begin
            m_tready = 1'b1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    m_tready = 1'b1;
                    rdy_hold = $urandom_range(0, 8);
                end
                6, 7, 8: begin
                    m_tready = 1'b0;
                    rdy_hold = $urandom_range(0, 3);
                end
                default: begin
                    m_tready = 1'b0;
                    rdy_hold = $urandom_range(10, 60);
                end
            endcase
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // idle cycles ahead of a request
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // one request: valid stays high across back-to-back requests, dropped only for a gap
    task automatic send(input logic mode, input int xs, input int ys, input int xe,
                        input int ye);
        int                             gap;
        logic [dlr_pkg::IN_TDATA_W-1:0] word;
        gap  = pick_gap();
        word = {PAD_W'(0), CB'(ye), CB'(xe), CB'(ys), CB'(xs)};
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = word;
        s_tuser  = mode;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        // keep count of the requests that make a point
        if (mode == dlr_pkg::MODE_LOAD) begin
            owed   = (magnitude(xe - xs) > magnitude(ye - ys)) ? magnitude(xe - xs)
                                                               : magnitude(ye - ys);
            useful = useful + 1;
        end else if (owed > 0) begin
            owed   = owed - 1;
            useful = useful + 1;
        end
    endtask

    // step requests carry junk endpoints, which the block must ignore
    task automatic advance(input int n);
        repeat (n)
            send(dlr_pkg::MODE_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    endtask

    task automatic write_reg(input logic [dlr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dlr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // stop requesting, wait for every point, then let the divider and queue settle
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // a load followed by steps; mostly short lines walked to the end, some left early,
    // some stepped past the end, and a few long lines cut short
    task automatic random_line();
        int xs, ys, xe, ye, span, len, n_steps, r;
        r = $urandom_range(0, 99);
        if (r < 85)
            span = $urandom_range(0, 16);
        else if (r < 98)
            span = $urandom_range(17, 128);
        else
            span = $urandom_range(129, COORD_MAX);
        xs = $urandom_range(0, COORD_MAX);
        ys = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 19) == 0) begin
            xe = $urandom_range(0, COORD_MAX);
            ye = $urandom_range(0, COORD_MAX);
        end else begin
            xe = clamp_coord(xs + $urandom_range(0, 2 * span) - span);
            ye = clamp_coord(ys + $urandom_range(0, 2 * span) - span);
        end
        len = (magnitude(xe - xs) > magnitude(ye - ys)) ? magnitude(xe - xs)
                                                        : magnitude(ye - ys);
        r = $urandom_range(0, 99);
        if (len > 64)
            n_steps = $urandom_range(0, 64);
        else if (r < 75)
            n_steps = len;
        else if (r < 88)
            n_steps = $urandom_range(0, len);
        else
            n_steps = len + $urandom_range(1, 3);
        send(dlr_pkg::MODE_LOAD, xs, ys, xe, ye);
        advance(n_steps);
    endtask

    initial begin
        int target;
        // synchronous reset held low at the start
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed part, with the registers at their reset values
        advance(1);                                         // step with no line
        send(dlr_pkg::MODE_LOAD, 0, 0, 0, 0);               // zero-length line
        advance(1);                                         // nothing left to step
        send(dlr_pkg::MODE_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send(dlr_pkg::MODE_LOAD, 0, 0, COORD_MAX, COORD_MAX);
        advance(2);
        send(dlr_pkg::MODE_LOAD, COORD_MAX, 0, 0, COORD_MAX);   // drops the active line
        advance(1);
        send(dlr_pkg::MODE_LOAD, 5, 5, 9, 7);               // half-pixel minor axis, ties
        advance(4);
        advance(1);                                         // step past the end
        send(dlr_pkg::MODE_LOAD, 30, 40, 27, 46);           // x falling, y major
        advance(6);
        send(dlr_pkg::MODE_LOAD, 1, COORD_MAX - 1, 2, COORD_MAX - 2);
        advance(1);
        drain();

        // random phases, each under its own colour and radius
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_reg(dlr_pkg::CFG_PIXEL_COLOR, '0);
                    write_reg(dlr_pkg::CFG_DOT_RADIUS, '0);
                end
                1: begin
                    write_reg(dlr_pkg::CFG_PIXEL_COLOR, '1);
                    write_reg(dlr_pkg::CFG_DOT_RADIUS, 32'd255);
                end
                default: begin
                    write_reg(dlr_pkg::CFG_DOT_RADIUS, $urandom_range(0, 255));
                    write_reg(dlr_pkg::CFG_PIXEL_COLOR, $urandom);
                end
            endcase
            calm   = (p == 1);
            target = useful + PHASE_REQS;
            while (useful < target) begin
                case ($urandom_range(0, 19))
                    0:       advance($urandom_range(1, 3));     // stray steps
                    1:       send(dlr_pkg::MODE_LOAD, $urandom_range(0, COORD_MAX),
                                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                  $urandom_range(0, COORD_MAX));
                    default: random_line();
                endcase
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
